@@ hdl/htg_pkg.sv @@
// ----------------------------------------------------------------------------
// htg_pkg
// Shared types, constants and the quarter-wave sine function of the tone
// generator.
// ----------------------------------------------------------------------------
package htg_pkg;

    // default sizes, handed to the top level parameters
    localparam int PHASE_BITS_DEF      = 32;
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int INDEX_BITS_DEF      = 20;

    // configuration field widths
    localparam int STEP_W   = 32;
    localparam int NOTE_W   = 20;
    localparam int FADE_W   = 16;
    localparam int GAIN_W   = 17;
    localparam int AMP_W    = 15;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int SAMPLE_W = 16;

    // register reset values
    localparam logic [STEP_W-1:0] PHASE_STEP_RST  = 32'd42852281;
    localparam logic [NOTE_W-1:0] NOTE_LENGTH_RST = 20'd8820;
    localparam logic [FADE_W-1:0] FADE_LENGTH_RST = 16'd529;
    localparam logic [GAIN_W-1:0] FADE_GAIN_RST   = 17'd124;
    localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd24576;

    // harmonic weights, Q15
    localparam logic [16:0] W_H1 = 17'd32768;
    localparam logic [16:0] W_H2 = 17'd4915;
    localparam logic [16:0] W_H3 = 17'd1638;

    localparam logic [16:0] ENV_ONE  = 17'd65536;
    localparam logic [14:0] SAT_MAX  = 15'd32767;

    localparam logic [63:0] ONE_Q30     = 64'h0000_0000_4000_0000;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        REG_PHASE_STEP  = 3'd0,
        REG_NOTE_LENGTH = 3'd1,
        REG_FADE_LENGTH = 3'd2,
        REG_FADE_GAIN   = 3'd3,
        REG_AMPLITUDE   = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        HARM_1 = 2'd0,
        HARM_2 = 2'd1,
        HARM_3 = 2'd2
    } harm_t;

    typedef struct packed {
        logic [STEP_W-1:0] phase_step;
        logic [NOTE_W-1:0] note_length;
        logic [FADE_W-1:0] fade_length;
        logic [GAIN_W-1:0] fade_gain;
        logic [AMP_W-1:0]  amplitude;
    } cfg_t;

    typedef struct packed {
        logic  load;
        logic  eval;
        logic  rd_en;
        harm_t rd_sel;
        logic  acc_en;
        logic  acc_clr;
        harm_t acc_sel;
        logic  env_mul;
        logic  env_clamp;
        logic  amp_mul;
        logic  mag;
        logic  mul;
        logic  put;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // first quarter of the sine, evaluated at elaboration only
    function automatic logic [15:0] quarter_sine(input logic [63:0] r, input int qbits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] q;
        x  = (r * HALF_PI_Q30) >> qbits;
        x2 = (x * x) >> 30;
        h  = ONE_Q30 - x2 / 64'd110;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
        h  = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
        s  = (x * h) >> 30;
        q  = (s * 64'd32767 + 64'h2000_0000) >> 30;
        if (q > 64'd32767)
        begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

endpackage

@@ hdl/htg_if.sv @@
// ----------------------------------------------------------------------------
// htg_if
// Valid/ready channels of the tone generator: sample ticks in, audio out.
// ----------------------------------------------------------------------------
interface htg_tick_if;
    logic valid;
    logic ready;
    logic start_req;

    modport source (output valid, output start_req, input ready);
    modport sink   (input valid, input start_req, output ready);
endinterface

interface htg_sample_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] sample;
    logic              last_sample;
    logic              active;

    modport source (output valid, output sample, output last_sample, output active,
                    input ready);
    modport sink   (input valid, input sample, input last_sample, input active,
                    output ready);
endinterface

@@ hdl/htg_regs.sv @@
// ----------------------------------------------------------------------------
// htg_regs
// APB register file holding the tone, note and gain settings.
// ----------------------------------------------------------------------------
module htg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [htg_pkg::ADDR_W-1:0]  paddr,
    input  logic [htg_pkg::DATA_W-1:0]  pwdata,
    output logic [htg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output htg_pkg::cfg_t               cfg
);
    import htg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PHASE_STEP:  cfg_next.phase_step  = pwdata[STEP_W-1:0];
                REG_NOTE_LENGTH: cfg_next.note_length = pwdata[NOTE_W-1:0];
                REG_FADE_LENGTH: cfg_next.fade_length = pwdata[FADE_W-1:0];
                REG_FADE_GAIN:   cfg_next.fade_gain   = pwdata[GAIN_W-1:0];
                REG_AMPLITUDE:   cfg_next.amplitude   = pwdata[AMP_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PHASE_STEP:  prdata = DATA_W'(cfg_reg.phase_step);
            REG_NOTE_LENGTH: prdata = DATA_W'(cfg_reg.note_length);
            REG_FADE_LENGTH: prdata = DATA_W'(cfg_reg.fade_length);
            REG_FADE_GAIN:   prdata = DATA_W'(cfg_reg.fade_gain);
            REG_AMPLITUDE:   prdata = DATA_W'(cfg_reg.amplitude);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step  <= PHASE_STEP_RST;
            cfg_reg.note_length <= NOTE_LENGTH_RST;
            cfg_reg.fade_length <= FADE_LENGTH_RST;
            cfg_reg.fade_gain   <= FADE_GAIN_RST;
            cfg_reg.amplitude   <= AMPLITUDE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ hdl/htg_ctrl.sv @@
// ----------------------------------------------------------------------------
// htg_ctrl
// Sequencer that walks one sample tick through the datapath.
// ----------------------------------------------------------------------------
module htg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output htg_pkg::cmd_t  cmd,
    input  htg_pkg::stat_t stat
);
    import htg_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EVAL = 8'b0000_0010,
        S_RD2  = 8'b0000_0100,
        S_RD3  = 8'b0000_1000,
        S_MIX  = 8'b0001_0000,
        S_MAG  = 8'b0010_0000,
        S_MUL  = 8'b0100_0000,
        S_PUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = HARM_1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = HARM_2;
                cmd.acc_en  = 1'b1;
                cmd.acc_clr = 1'b1;
                cmd.acc_sel = HARM_1;
                cmd.env_mul = 1'b1;
                state_next  = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = HARM_3;
                cmd.acc_en    = 1'b1;
                cmd.acc_sel   = HARM_2;
                cmd.env_clamp = 1'b1;
                state_next    = S_MIX;
            end
            S_MIX:
            begin
                cmd.acc_en  = 1'b1;
                cmd.acc_sel = HARM_3;
                cmd.amp_mul = 1'b1;
                state_next  = S_MAG;
            end
            S_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                // hold here until the output register is free
                if (stat.out_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/htg_datapath.sv @@
// ----------------------------------------------------------------------------
// htg_datapath
// Phase and index state, sine ROM, harmonic mix, envelope and output register.
// ----------------------------------------------------------------------------
module htg_datapath #(
    parameter int PHASE_BITS      = htg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = htg_pkg::SINE_TABLE_BITS_DEF,
    parameter int INDEX_BITS      = htg_pkg::INDEX_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  htg_pkg::cmd_t                 cmd,
    output htg_pkg::stat_t                stat,
    input  htg_pkg::cfg_t                 cfg,
    input  logic                          start_req,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [htg_pkg::SAMPLE_W-1:0] sample,
    output logic                          last_sample,
    output logic                          active
);
    import htg_pkg::*;

    localparam int QBITS       = SINE_TABLE_BITS - 2;
    localparam int QUARTER_LEN = 1 << QBITS;
    localparam int AW          = SINE_TABLE_BITS - 1;
    localparam int CW          = ((INDEX_BITS > NOTE_W) ? INDEX_BITS : NOTE_W) + 2;

    localparam logic [AW-1:0] QL_A = AW'(QUARTER_LEN);

    typedef logic [15:0] qtab_t [0:QUARTER_LEN];

    function automatic qtab_t build_qtab();
        qtab_t t;
        for (int k = 0; k <= QUARTER_LEN; k++)
        begin
            t[k] = quarter_sine(64'(k), QBITS);
        end
        return t;
    endfunction

    localparam qtab_t QTAB = build_qtab();

    // architectural state
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [INDEX_BITS-1:0] sample_index_reg;
    logic                  sounding_reg;

    // working copy of one tick
    logic [PHASE_BITS-1:0] ph_w_reg;
    logic [PHASE_BITS-1:0] ph3_reg;
    logic [INDEX_BITS-1:0] idx_w_reg;
    logic                  snd_w_reg;
    logic                  live_reg;
    logic                  last_reg;
    logic                  env_one_reg;
    logic [15:0]           env_op_reg;
    logic [32:0]           env_raw_reg;
    logic [16:0]           env_reg;
    logic [31:0]           ae_reg;
    logic signed [31:0]    acc_reg;
    logic [30:0]           mag_reg;
    logic                  neg_reg;
    logic [62:0]           prod_reg;
    logic [15:0]           rom_q_reg;
    logic                  rom_neg_reg;

    logic                  out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                  last_sample_reg;
    logic                  active_reg;

    logic [CW-1:0]              idx_ext;
    logic [CW-1:0]              note_ext;
    logic [CW-1:0]              fade_ext;
    logic [PHASE_BITS-1:0]      ph_sel;
    logic [SINE_TABLE_BITS-1:0] tab_k;
    logic [AW-1:0]              rom_addr;
    logic [16:0]                weight;
    logic signed [15:0]         rom_val;
    logic signed [33:0]         term;
    logic signed [31:0]         acc_base;
    logic [16:0]                shifted;
    logic [14:0]                sat_mag;
    logic signed [SAMPLE_W-1:0] sat_val;

    assign idx_ext  = CW'(idx_w_reg);
    assign note_ext = CW'(cfg.note_length);
    assign fade_ext = CW'(cfg.fade_length);

    // phase multiple for the current ROM read
    always_comb
    begin
        case (cmd.rd_sel)
            HARM_1:  ph_sel = ph_w_reg;
            HARM_2:  ph_sel = {ph_w_reg[PHASE_BITS-2:0], 1'b0};
            HARM_3:  ph_sel = ph3_reg;
            default: ph_sel = ph_w_reg;
        endcase
    end

    assign tab_k    = ph_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign rom_addr = tab_k[QBITS] ? (QL_A - AW'(tab_k[QBITS-1:0]))
                                   : AW'(tab_k[QBITS-1:0]);

    always_comb
    begin
        case (cmd.acc_sel)
            HARM_1:  weight = W_H1;
            HARM_2:  weight = W_H2;
            HARM_3:  weight = W_H3;
            default: weight = W_H1;
        endcase
    end

    assign rom_val  = rom_neg_reg ? -$signed(rom_q_reg) : $signed(rom_q_reg);
    assign term     = rom_val * $signed({1'b0, weight});
    assign acc_base = cmd.acc_clr ? 32'sd0 : acc_reg;

    // truncate toward zero on the magnitude, then saturate
    assign shifted = prod_reg[62:46];
    assign sat_mag = (shifted > 17'(SAT_MAX)) ? SAT_MAX : shifted[14:0];
    assign sat_val = neg_reg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign sample        = sample_reg;
    assign last_sample   = last_sample_reg;
    assign active        = active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
            sounding_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.put)
            begin
                out_valid_reg <= 1'b1;
                if (live_reg)
                begin
                    sample_index_reg <= INDEX_BITS'(idx_ext + CW'(1));
                    phase_acc_reg    <= ph_w_reg + PHASE_BITS'(cfg.phase_step);
                    sounding_reg     <= !last_reg;
                end
                else
                begin
                    sample_index_reg <= idx_w_reg;
                    phase_acc_reg    <= ph_w_reg;
                    sounding_reg     <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            snd_w_reg <= start_req || sounding_reg;
            idx_w_reg <= start_req ? '0 : sample_index_reg;
            ph_w_reg  <= start_req ? '0 : phase_acc_reg;
        end
        if (cmd.eval)
        begin
            live_reg    <= snd_w_reg && (idx_ext < note_ext);
            last_reg    <= (idx_ext + CW'(1)) == note_ext;
            env_one_reg <= !(idx_ext < fade_ext) && !((idx_ext + fade_ext) > note_ext);
            env_op_reg  <= (idx_ext < fade_ext) ? 16'(idx_ext) : 16'(note_ext - idx_ext);
            ph3_reg     <= ph_w_reg + {ph_w_reg[PHASE_BITS-2:0], 1'b0};
        end
        if (cmd.rd_en)
        begin
            rom_q_reg   <= QTAB[rom_addr];
            rom_neg_reg <= tab_k[SINE_TABLE_BITS-1];
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_base + 32'(term);
        end
        if (cmd.env_mul)
        begin
            env_raw_reg <= 33'(env_op_reg) * 33'(cfg.fade_gain);
        end
        if (cmd.env_clamp)
        begin
            env_reg <= (env_one_reg || (env_raw_reg > 33'(ENV_ONE))) ? ENV_ONE
                                                                     : env_raw_reg[16:0];
        end
        if (cmd.amp_mul)
        begin
            ae_reg <= 32'(cfg.amplitude) * 32'(env_reg);
        end
        if (cmd.mag)
        begin
            neg_reg <= acc_reg[31];
            mag_reg <= acc_reg[31] ? 31'(-acc_reg) : acc_reg[30:0];
        end
        if (cmd.mul)
        begin
            prod_reg <= 63'(mag_reg) * 63'(ae_reg);
        end
        if (cmd.put)
        begin
            sample_reg      <= live_reg ? sat_val : '0;
            last_sample_reg <= live_reg && last_reg;
            active_reg      <= live_reg;
        end
    end

endmodule

@@ hdl/harmonic_tone_generator_unit.sv @@
// ----------------------------------------------------------------------------
// harmonic_tone_generator_unit
// Sine tone with second and third harmonics under an attack/release envelope.
//
//  channel     dir   handshake       payload
//  tick_ch     in    valid/ready     start_req
//  sample_ch   out   valid/ready     sample, last_sample, active
//  apb         in    psel/penable    phase_step, note_length, fade_length,
//                                    fade_gain, amplitude
//
//  from transfer to result in the output register, the sequencer walks
//  three reads of the single-port sine ROM, the envelope multiply, the gain
//  multiply and the final 31x32 product in turn.
//  a new tick is taken the cycle after the previous result is loaded, so a
//  waiting result does not hold off the next tick; a stalled output holds
//  the sequencer in its last step. reset clears phase, index and note state.
// ----------------------------------------------------------------------------
module harmonic_tone_generator_unit #(
    parameter int PHASE_BITS      = htg_pkg::PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = htg_pkg::SINE_TABLE_BITS_DEF,
    parameter int INDEX_BITS      = htg_pkg::INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [htg_pkg::ADDR_W-1:0]  paddr,
    input  logic [htg_pkg::DATA_W-1:0]  pwdata,
    output logic [htg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    htg_tick_if.sink                    tick_ch,
    htg_sample_if.source                sample_ch
);
    import htg_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    htg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    htg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tick_ch.valid),
        .in_ready (tick_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    htg_datapath #(
        .PHASE_BITS      (PHASE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .INDEX_BITS      (INDEX_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .start_req   (tick_ch.start_req),
        .out_valid   (sample_ch.valid),
        .out_ready   (sample_ch.ready),
        .sample      (sample_ch.sample),
        .last_sample (sample_ch.last_sample),
        .active      (sample_ch.active)
    );

endmodule

@@ hdl/htg_checker.sv @@
// ----------------------------------------------------------------------------
// htg_checker
// Port-level checks on the audio output channel, bound to the top level.
// ----------------------------------------------------------------------------
module htg_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              valid,
    input logic              ready,
    input logic signed [15:0] sample,
    input logic              last_sample,
    input logic              active
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("output valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(sample) && $stable(last_sample) && $stable(active))
        else $error("output payload changed while stalled");

    // silence outside a note, and last only on a sounding sample
    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !active |-> sample == 16'sd0 && !last_sample)
        else $error("inactive sample not silent");

    // saturation is symmetric
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> sample != 16'sh8000)
        else $error("sample outside saturation range");

endmodule

bind harmonic_tone_generator_unit htg_checker u_htg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (sample_ch.valid),
    .ready       (sample_ch.ready),
    .sample      (sample_ch.sample),
    .last_sample (sample_ch.last_sample),
    .active      (sample_ch.active)
);
